### rtl/afahb_pkg.sv
`timescale 1ns / 1ps

package afahb_pkg;

    // Input opcodes
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Result kinds
    localparam logic KIND_HDR   = 1'b0;
    localparam logic KIND_ENTRY = 1'b1;

    localparam int          LEN_W      = 14;
    localparam int          CNT_W      = 6;
    localparam int          TYPE_W     = 7;
    localparam int          RATE_W     = 5;
    localparam logic [13:0] LEN_MAX    = 14'h3FFF;
    localparam logic [13:0] LEN_START  = 14'd1;
    localparam logic [13:0] MTU_RESET  = 14'd1500;
    localparam logic [7:0]  ENTRY_LOW  = 8'h01;

    // One closed packet, handed from front to back
    typedef struct packed {
        logic              bank;
        logic [CNT_W-1:0]  count;
        logic [7:0]        hdr;
        logic [LEN_W-1:0]  len;
    } t_close_cmd;

    // Back reports that it has finished reading a bank
    typedef struct packed {
        logic done;
        logic bank;
    } t_back_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HDR,
        S_READ,
        S_ENTRY
    } t_back_state;

endpackage

### rtl/afahb_ram.sv
`timescale 1ns / 1ps

module afahb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/afahb_queue.sv
`timescale 1ns / 1ps

module afahb_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  afahb_pkg::t_close_cmd i_data,
    output logic                  o_full,
    input  logic                  i_pop,
    output afahb_pkg::t_close_cmd o_data,
    output logic                  o_empty
);

    afahb_pkg::t_close_cmd r_mem [2];
    logic                  r_wptr;
    logic                  r_rptr;
    logic [1:0]            r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (do_push) begin
                r_wptr <= ~r_wptr;
            end
            if (do_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

endmodule

### rtl/afahb_front.sv
`timescale 1ns / 1ps

module afahb_front #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic [13:0]                            i_mtu,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic                                   i_opcode,
    input  logic [7:0]                             i_frame_type_byte,
    input  logic [7:0]                             i_mode_byte,
    input  logic [13:0]                            i_frame_size,
    output logic                                   o_push,
    output afahb_pkg::t_close_cmd                  o_cmd,
    input  logic                                   i_q_full,
    input  afahb_pkg::t_back_status                i_status,
    output logic                                   o_wr_en,
    output logic [$clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2):0] o_wr_addr,
    output logic [afahb_pkg::TYPE_W-1:0]           o_wr_data
);

    localparam int IdxW = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);
    localparam int CntW = $clog2(MAX_FRAMES + 1);

    logic [CntW-1:0]              r_count, n_count;
    logic [afahb_pkg::LEN_W-1:0]  r_len, n_len;
    logic [afahb_pkg::RATE_W-1:0] r_rate, n_rate;
    logic                         r_rate_vld, n_rate_vld;
    logic [7:0]                   r_first_mode, n_first_mode;
    logic                         r_bank, n_bank;
    logic [1:0]                   r_pending, n_pending;

    logic                         is_flush;
    logic [afahb_pkg::RATE_W-1:0] next_rate;
    logic [afahb_pkg::RATE_W-1:0] cur_rate;
    logic [14:0]                  sum_cur;
    logic [14:0]                  sum_new;
    logic [13:0]                  len_base;
    logic [CntW-1:0]              count_base;
    logic                         close_req;
    logic                         do_close;
    logic                         accept;
    logic                         wbank;

    always_comb begin
        is_flush   = (i_opcode == afahb_pkg::OP_FLUSH);
        next_rate  = i_mode_byte[4:0];
        cur_rate   = r_rate_vld ? r_rate : next_rate;
        sum_cur    = {1'b0, r_len} + {1'b0, i_frame_size};
        close_req  = is_flush || (next_rate != cur_rate) || (sum_cur > {1'b0, i_mtu})
                     || (r_count >= CntW'(MAX_FRAMES));
        do_close   = close_req && (r_count != '0);
        // A close flips to the other bank, which must be drained by the back
        o_ready    = !do_close || (!r_pending[~r_bank] && !i_q_full);
        accept     = i_valid && o_ready;

        len_base   = do_close ? afahb_pkg::LEN_START : r_len;
        count_base = do_close ? '0 : r_count;
        sum_new    = {1'b0, len_base} + {1'b0, i_frame_size};
        wbank      = do_close ? ~r_bank : r_bank;

        o_push        = accept && do_close;
        o_cmd.bank    = r_bank;
        o_cmd.count   = afahb_pkg::CNT_W'(r_count);
        o_cmd.hdr     = {r_first_mode[4:0], r_first_mode[7:6], 1'b0};
        o_cmd.len     = r_len;

        o_wr_en   = accept && !is_flush;
        o_wr_addr = {wbank, count_base[IdxW-1:0]};
        o_wr_data = i_frame_type_byte[6:0];

        n_count      = r_count;
        n_len        = r_len;
        n_rate       = r_rate;
        n_rate_vld   = r_rate_vld;
        n_first_mode = r_first_mode;
        n_bank       = r_bank;
        n_pending    = r_pending;

        if (i_status.done) begin
            n_pending[i_status.bank] = 1'b0;
        end

        if (accept) begin
            if (do_close) begin
                n_pending[r_bank] = 1'b1;
                n_bank            = ~r_bank;
                n_count           = '0;
                n_len             = afahb_pkg::LEN_START;
            end
            if (!is_flush) begin
                n_rate     = next_rate;
                n_rate_vld = 1'b1;
                if (count_base == '0) begin
                    n_first_mode = i_mode_byte;
                end
                n_count = count_base + CntW'(1);
                n_len   = sum_new[14] ? afahb_pkg::LEN_MAX : sum_new[13:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_len        <= afahb_pkg::LEN_START;
            r_rate       <= '0;
            r_rate_vld   <= 1'b0;
            r_first_mode <= 8'd0;
            r_bank       <= 1'b0;
            r_pending    <= 2'b00;
        end else begin
            r_count      <= n_count;
            r_len        <= n_len;
            r_rate       <= n_rate;
            r_rate_vld   <= n_rate_vld;
            r_first_mode <= n_first_mode;
            r_bank       <= n_bank;
            r_pending    <= n_pending;
        end
    end

endmodule

### rtl/afahb_back.sv
`timescale 1ns / 1ps

module afahb_back #(
    parameter int MAX_FRAMES = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_q_empty,
    input  afahb_pkg::t_close_cmd                  i_cmd,
    output logic                                   o_pop,
    output afahb_pkg::t_back_status                o_status,
    output logic                                   o_rd_en,
    output logic [$clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2):0] o_rd_addr,
    input  logic [afahb_pkg::TYPE_W-1:0]           i_rd_data,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic                                   o_word_kind,
    output logic [15:0]                            o_header_word,
    output logic [13:0]                            o_packet_length,
    output logic                                   o_last_word
);

    localparam int IdxW = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);

    afahb_pkg::t_back_state r_state, n_state;
    afahb_pkg::t_close_cmd  r_cmd, n_cmd;
    logic [IdxW-1:0]        r_idx, n_idx;
    logic                   r_ovalid, n_ovalid;
    logic                   r_kind, n_kind;
    logic [15:0]            r_word, n_word;
    logic [13:0]            r_len, n_len;
    logic                   r_last, n_last;
    logic                   out_free;
    logic                   is_last;

    always_comb begin
        out_free = !r_ovalid || i_ready;
        is_last  = ((afahb_pkg::CNT_W'(r_idx) + afahb_pkg::CNT_W'(1)) == r_cmd.count);

        n_state  = r_state;
        n_cmd    = r_cmd;
        n_idx    = r_idx;
        n_ovalid = r_ovalid && !i_ready;
        n_kind   = r_kind;
        n_word   = r_word;
        n_len    = r_len;
        n_last   = r_last;
        o_pop    = 1'b0;
        o_rd_en  = 1'b0;
        o_status = '{done: 1'b0, bank: r_cmd.bank};

        unique case (r_state)
            afahb_pkg::S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_cmd;
                    n_idx   = '0;
                    n_state = afahb_pkg::S_HDR;
                end
            end
            afahb_pkg::S_HDR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_kind   = afahb_pkg::KIND_HDR;
                    n_word   = {8'h00, r_cmd.hdr};
                    n_len    = '0;
                    n_last   = 1'b0;
                    n_state  = afahb_pkg::S_READ;
                end
            end
            afahb_pkg::S_READ: begin
                o_rd_en = 1'b1;
                n_state = afahb_pkg::S_ENTRY;
            end
            afahb_pkg::S_ENTRY: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_kind   = afahb_pkg::KIND_ENTRY;
                    n_word   = {~is_last, i_rd_data, afahb_pkg::ENTRY_LOW};
                    n_len    = is_last ? r_cmd.len : '0;
                    n_last   = is_last;
                    if (is_last) begin
                        o_status.done = 1'b1;
                        n_state       = afahb_pkg::S_IDLE;
                    end else begin
                        n_idx   = r_idx + IdxW'(1);
                        n_state = afahb_pkg::S_READ;
                    end
                end
            end
            default: begin
                n_state = afahb_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rd_addr       = {r_cmd.bank, r_idx};
    assign o_valid         = r_ovalid;
    assign o_word_kind     = r_kind;
    assign o_header_word   = r_word;
    assign o_packet_length = r_len;
    assign o_last_word     = r_last;

    always_ff @(posedge i_clk) begin
        r_cmd  <= n_cmd;
        r_idx  <= n_idx;
        r_kind <= n_kind;
        r_word <= n_word;
        r_len  <= n_len;
        r_last <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= afahb_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

### rtl/audio_frame_aggregation_header_builder_core.sv
`timescale 1ns / 1ps

// Audio frame aggregation header builder. Each input transaction is either a
// frame descriptor (frame-type byte, mode byte, frame size) or a flush. Frames
// are gathered into a packet; the packet is closed before a new frame when the
// frame's 5-bit sample-rate index changes, when the packet would grow past the
// MTU (i_cfg_data, reset 1500), or when MAX_FRAMES frames are already held.
// A flush closes the packet too; closing an empty packet yields nothing. A
// closed packet comes out as one common header byte (index<<3 | TFI<<1 from
// the first frame's mode byte) followed by one 16-bit table entry per frame
// (more flag, 7-bit type, low byte 1); the last transaction carries the
// packet length, which saturates at 16383. A frame that does not close a
// packet is never held off. The back end takes a closed packet from the
// queue, emits the header byte and then, for each frame, reads its type
// from a registered RAM before it presents that table entry; the header
// and each entry wait while the output is stalled. Frame types sit
// in two banks of that RAM, so the front keeps taking frames for the next
// packet while the back drains the previous one; the front holds off only a
// transaction that would close a second packet before the first is drained.
// Write the MTU only while the block is idle.
module audio_frame_aggregation_header_builder_core #(
    parameter int MAX_FRAMES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [13:0] i_cfg_data,
    // input transactions
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_opcode,
    input  logic [7:0]  i_frame_type_byte,
    input  logic [7:0]  i_mode_byte,
    input  logic [13:0] i_frame_size,
    // result transactions
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_word_kind,
    output logic [15:0] o_header_word,
    output logic [13:0] o_packet_length,
    output logic        o_last_word
);

    localparam int IdxW  = $clog2(MAX_FRAMES > 1 ? MAX_FRAMES : 2);
    localparam int AddrW = IdxW + 1;

    logic [13:0]              r_mtu;
    logic                     q_push;
    logic                     q_pop;
    logic                     q_full;
    logic                     q_empty;
    afahb_pkg::t_close_cmd    q_in;
    afahb_pkg::t_close_cmd    q_out;
    afahb_pkg::t_back_status  back_status;
    logic                     wr_en;
    logic [AddrW-1:0]         wr_addr;
    logic [afahb_pkg::TYPE_W-1:0] wr_data;
    logic                     rd_en;
    logic [AddrW-1:0]         rd_addr;
    logic [afahb_pkg::TYPE_W-1:0] rd_data;

    // Always take configuration writes
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mtu <= afahb_pkg::MTU_RESET;
        end else if (i_cfg_valid) begin
            r_mtu <= i_cfg_data;
        end
    end

    // Front: classify each transaction, keep the packet bookkeeping, store types
    afahb_front #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_mtu             (r_mtu),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_opcode          (i_opcode),
        .i_frame_type_byte (i_frame_type_byte),
        .i_mode_byte       (i_mode_byte),
        .i_frame_size      (i_frame_size),
        .o_push            (q_push),
        .o_cmd             (q_in),
        .i_q_full          (q_full),
        .i_status          (back_status),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_wr_data         (wr_data)
    );

    // Two banks of frame types, one being filled and one being drained
    afahb_ram #(
        .WIDTH (afahb_pkg::TYPE_W),
        .DEPTH (2 ** AddrW)
    ) u_types (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    // Closed packets waiting for the back end
    afahb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    // Back: emit header and table entries through the output register
    afahb_back #(
        .MAX_FRAMES (MAX_FRAMES)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_cmd           (q_out),
        .o_pop           (q_pop),
        .o_status        (back_status),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .i_rd_data       (rd_data),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_word_kind     (o_word_kind),
        .o_header_word   (o_header_word),
        .o_packet_length (o_packet_length),
        .o_last_word     (o_last_word)
    );

endmodule

### rtl/afahb_checker.sv
`timescale 1ns / 1ps

module afahb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_word_kind,
    input logic [15:0] o_header_word,
    input logic [13:0] o_packet_length,
    input logic        o_last_word
);

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_header_word) && $stable(o_last_word))
        else $error("result dropped or changed while stalled");

    // Length only on the final result
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_word |-> o_packet_length == 14'd0)
        else $error("packet length on a non-final result");

    // Header byte never ends a packet and has its fixed zero bits
    a_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word_kind == afahb_pkg::KIND_HDR |->
            !o_last_word && o_header_word[15:8] == 8'h00 && !o_header_word[0])
        else $error("malformed header byte");

    // Entry more flag is the inverse of last
    a_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_word_kind == afahb_pkg::KIND_ENTRY |->
            o_header_word[7:0] == afahb_pkg::ENTRY_LOW && o_header_word[15] == !o_last_word)
        else $error("malformed table entry");

endmodule

bind audio_frame_aggregation_header_builder_core afahb_checker u_afahb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_ready         (i_ready),
    .o_word_kind     (o_word_kind),
    .o_header_word   (o_header_word),
    .o_packet_length (o_packet_length),
    .o_last_word     (o_last_word)
);
